// ----- rtl/chgs_pkg.sv -----
`default_nettype none

package chgs_pkg;

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned MINUTE_W = 11;
  localparam int unsigned TAP_W    = 7;
  localparam int unsigned HW_W     = 7;
  localparam int unsigned COUNT_W  = 20;
  localparam int unsigned WEIGHT_W = 20;
  localparam int unsigned PROD_W   = COUNT_W + WEIGHT_W;
  localparam int unsigned SUM_W    = 52;

  // Parameter defaults
  localparam int unsigned NUM_BINS_DEF       = 1440;
  localparam int unsigned MAX_HALF_WIDTH_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_WR,
    ST_QRY_ISSUE,
    ST_QRY_DRAIN,
    ST_RESP
  } state_e;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/chgs_ram.sv -----
`default_nettype none

module chgs_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/chgs_mac.sv -----
`default_nettype none

module chgs_mac (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire chgs_pkg::mac_ctrl_t             ctrl_i,
  input  wire logic [chgs_pkg::COUNT_W-1:0]    a_i,
  input  wire logic [chgs_pkg::WEIGHT_W-1:0]   b_i,
  output logic                                 busy_o,
  output logic      [chgs_pkg::SUM_W-1:0]      acc_o
);

  import chgs_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic              pv_q;
  logic [SUM_W-1:0]  acc_q;
  logic [SUM_W-1:0]  acc_d;
  logic [SUM_W:0]    sum;

  // Multiply stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.vld;
    end
  end

  // Accumulate with saturation at the full 52-bit range
  always_comb begin
    sum   = {1'b0, acc_q} + (SUM_W + 1)'(prod_q);
    acc_d = sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_d;
    end
  end

  assign busy_o = pv_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

// ----- rtl/circular_histogram_gaussian_smoother.sv -----
`default_nettype none
// A query sums over the bins within h of the minute, wrapping around the day,
//   h being the half width saturated at MAX_HALF_WIDTH.
// Throughput: one request at a time; the next request is taken once the result is in the
//   output register. A query reads one bin and one weight per cycle over the bin and weight memory ports.
// Reset: asynchronous, active low; then a clearing pass over max(NUM_BINS, MAX_HALF_WIDTH+1)
//   addresses (1440 by default) zeroes both memories while no request is taken.

module circular_histogram_gaussian_smoother #(
  parameter int unsigned NUM_BINS       = chgs_pkg::NUM_BINS_DEF,
  parameter int unsigned MAX_HALF_WIDTH = chgs_pkg::MAX_HALF_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [chgs_pkg::HW_W-1:0]        cfg_half_width_i,
  // Requests
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [chgs_pkg::CMD_W-1:0]       command_i,
  input  wire logic [chgs_pkg::MINUTE_W-1:0]    minute_i,
  input  wire logic [chgs_pkg::TAP_W-1:0]       tap_i,
  input  wire logic [chgs_pkg::WEIGHT_W-1:0]    weight_i,
  // Results
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [chgs_pkg::COUNT_W-1:0]     exact_count_o,
  output logic      [chgs_pkg::SUM_W-1:0]       smoothed_value_o
);

  import chgs_pkg::*;

  localparam int unsigned WGT_DEPTH = MAX_HALF_WIDTH + 1;
  localparam int unsigned BIN_AW    = $clog2(NUM_BINS);
  localparam int unsigned WGT_AW    = $clog2(WGT_DEPTH);
  localparam int unsigned CLR_DEPTH = (NUM_BINS > WGT_DEPTH) ? NUM_BINS : WGT_DEPTH;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);
  localparam logic [BIN_AW-1:0] BIN_LAST = BIN_AW'(NUM_BINS - 1);
  localparam logic [CLR_W-1:0]  CLR_LAST = CLR_W'(CLR_DEPTH - 1);

  state_e state_q, state_d;

  // Configuration register
  logic [HW_W-1:0] hw_q;

  // Sequencer registers
  logic [CLR_W-1:0]  clr_q;
  logic [BIN_AW-1:0] addr_q;
  logic [BIN_AW-1:0] up_q;
  logic [BIN_AW-1:0] dn_q;
  logic [WGT_AW-1:0] tap_q;
  logic [WGT_AW-1:0] h_q;
  logic              dir_q;
  logic              v1_q;
  logic              cap_q;
  logic [COUNT_W-1:0] res_count_q;
  logic               out_valid_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [SUM_W-1:0]   out_smooth_q;

  // Decoded request
  cmd_e              cmd;
  logic              accept;
  logic              min_ok;
  logic              tap_ok;
  logic [BIN_AW-1:0] min_addr;
  logic [31:0]       hw_sat;
  logic [WGT_AW-1:0] h_eff;
  logic [BIN_AW-1:0] up_nxt;
  logic [BIN_AW-1:0] dn_nxt;
  logic              out_free;
  logic              clr_bin_ok;
  logic              clr_wgt_ok;

  // Memory ports
  logic                bin_we, bin_re;
  logic [BIN_AW-1:0]   bin_waddr, bin_raddr;
  logic [COUNT_W-1:0]  bin_wdata, bin_rdata;
  logic                wgt_we, wgt_re;
  logic [WGT_AW-1:0]   wgt_waddr, wgt_raddr;
  logic [WEIGHT_W-1:0] wgt_wdata, wgt_rdata;
  logic [COUNT_W-1:0]  inc_count;

  // Multiply-accumulate
  mac_ctrl_t          mac_ctrl;
  logic               mac_busy;
  logic [SUM_W-1:0]   mac_acc;
  logic               iss;

  assign cmd      = cmd_e'(command_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign min_ok   = 32'(minute_i) < NUM_BINS;
  assign tap_ok   = 32'(tap_i) <= MAX_HALF_WIDTH;
  assign min_addr = BIN_AW'(minute_i);
  assign hw_sat   = (32'(hw_q) > MAX_HALF_WIDTH) ? 32'(MAX_HALF_WIDTH) : 32'(hw_q);
  assign h_eff    = WGT_AW'(hw_sat);
  assign up_nxt   = (up_q == BIN_LAST) ? '0 : up_q + 1'b1;
  assign dn_nxt   = (dn_q == '0) ? BIN_LAST : dn_q - 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;
  assign clr_bin_ok = {1'b0, clr_q} < (CLR_W + 1)'(NUM_BINS);
  assign clr_wgt_ok = {1'b0, clr_q} < (CLR_W + 1)'(WGT_DEPTH);
  assign inc_count  = (bin_rdata == {COUNT_W{1'b1}}) ? bin_rdata : bin_rdata + 1'b1;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= '0;
    end else if (cfg_valid_i) begin
      hw_q <= cfg_half_width_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RESP;
          if (cmd == CMD_ADD && min_ok) begin
            state_d = ST_ADD_WR;
          end else if (cmd == CMD_QUERY && min_ok) begin
            state_d = (h_eff == '0) ? ST_QRY_DRAIN : ST_QRY_ISSUE;
          end
        end
      end
      ST_ADD_WR: state_d = ST_RESP;
      ST_QRY_ISSUE: begin
        if (dir_q && tap_q == h_q) state_d = ST_QRY_DRAIN;
      end
      ST_QRY_DRAIN: begin
        if (!v1_q && !mac_busy) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Memory and pipeline control per state
  always_comb begin
    bin_we    = 1'b0;
    bin_waddr = BIN_AW'(clr_q);
    bin_wdata = '0;
    bin_re    = 1'b0;
    bin_raddr = min_addr;
    wgt_we    = 1'b0;
    wgt_waddr = WGT_AW'(clr_q);
    wgt_wdata = '0;
    wgt_re    = 1'b0;
    wgt_raddr = '0;
    iss       = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        bin_we = clr_bin_ok;
        wgt_we = clr_wgt_ok;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_ADD: begin
              bin_re = min_ok;
            end
            CMD_LOAD: begin
              wgt_we    = tap_ok;
              wgt_waddr = WGT_AW'(tap_i);
              wgt_wdata = weight_i;
            end
            CMD_QUERY: begin
              bin_re = min_ok;
              wgt_re = min_ok;
              iss    = min_ok;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_WR: begin
        bin_we    = 1'b1;
        bin_waddr = addr_q;
        bin_wdata = inc_count;
      end
      ST_QRY_ISSUE: begin
        bin_re    = 1'b1;
        wgt_re    = 1'b1;
        iss       = 1'b1;
        bin_raddr = dir_q ? dn_nxt : up_nxt;
        wgt_raddr = dir_q ? tap_q : tap_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign mac_ctrl.clr = accept;
  assign mac_ctrl.vld = v1_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      v1_q        <= 1'b0;
      cap_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= iss;
      cap_q   <= iss && (state_q == ST_IDLE);
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      // Load the result, or drop it once taken
      if (state_q == ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Window walk: center first, then alternate up and down per tap
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= min_addr;
      up_q   <= min_addr;
      dn_q   <= min_addr;
      tap_q  <= '0;
      dir_q  <= 1'b0;
      h_q    <= h_eff;
    end else if (state_q == ST_QRY_ISSUE) begin
      dir_q <= !dir_q;
      if (dir_q) begin
        dn_q <= dn_nxt;
      end else begin
        up_q  <= up_nxt;
        tap_q <= tap_q + 1'b1;
      end
    end
  end

  // Exact count: incremented value for add, center bin for query
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_count_q <= '0;
    end else if (state_q == ST_ADD_WR) begin
      res_count_q <= inc_count;
    end else if (cap_q) begin
      res_count_q <= bin_rdata;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP && out_free) begin
      out_count_q  <= res_count_q;
      out_smooth_q <= mac_acc;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign exact_count_o    = out_count_q;
  assign smoothed_value_o = out_smooth_q;

  chgs_ram #(
    .DEPTH (NUM_BINS),
    .WIDTH (COUNT_W)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_waddr),
    .wdata_i (bin_wdata),
    .re_i    (bin_re),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  chgs_ram #(
    .DEPTH (WGT_DEPTH),
    .WIDTH (WEIGHT_W)
  ) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .waddr_i (wgt_waddr),
    .wdata_i (wgt_wdata),
    .re_i    (wgt_re),
    .raddr_i (wgt_raddr),
    .rdata_o (wgt_rdata)
  );

  chgs_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (bin_rdata),
    .b_i    (wgt_rdata),
    .busy_o (mac_busy),
    .acc_o  (mac_acc)
  );

endmodule

`default_nettype wire

// ----- dv/circular_histogram_gaussian_smoother_tb.sv -----
`default_nettype none

module circular_histogram_gaussian_smoother_tb;
  import chgs_pkg::*;

  localparam int NUM_BINS = NUM_BINS_DEF;
  localparam int MAX_HW   = MAX_HALF_WIDTH_DEF;
  localparam bit [COUNT_W-1:0] COUNT_MAX = '1;
  localparam bit [63:0] SUM_MAX = (64'd1 << SUM_W) - 64'd1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 140;

  typedef struct {
    bit [COUNT_W-1:0] count;
    bit [SUM_W-1:0]   smooth;
  } hist_result_t;

  // DUT ports, inputs driven from time zero
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [HW_W-1:0]      cfg_half_width = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     command = CMD_NOP;
  logic [MINUTE_W-1:0]  minute = '0;
  logic [TAP_W-1:0]     tap = '0;
  logic [WEIGHT_W-1:0]  weight = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COUNT_W-1:0]   exact_count;
  logic [SUM_W-1:0]     smoothed_value;

  // Shadow of the histogram, the kernel and the half width register
  bit [COUNT_W-1:0]  bin_count [NUM_BINS];
  bit [WEIGHT_W-1:0] tap_weight [MAX_HW+1];
  bit [HW_W-1:0]     half_width;

  hist_result_t histogram_outputs_q [$];

  bit src_bursts = 1'b1;
  bit sink_bursts = 1'b1;
  int sink_hold = 0;
  int cycles = 0;
  int errors = 0;
  int results_checked = 0;
  int n_add = 0, n_load = 0, n_query = 0, n_nop = 0, n_settings = 0;

  circular_histogram_gaussian_smoother dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_half_width_i (cfg_half_width),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .minute_i         (minute),
    .tap_i            (tap),
    .weight_i         (weight),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .exact_count_o    (exact_count),
    .smoothed_value_o (smoothed_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               histogram_outputs_q.size());
      $display("circular_histogram_gaussian_smoother test failed");
      $finish;
    end
  end

  // Apply one request to the shadow state and return the result it produces
  function automatic hist_result_t histogram_update(cmd_e cmd, bit [MINUTE_W-1:0] min,
                                                    bit [TAP_W-1:0] tp, bit [WEIGHT_W-1:0] w);
    hist_result_t r;
    int h;
    int idx;
    bit [63:0] prod;
    bit [63:0] acc;
    r.count = '0;
    r.smooth = '0;
    case (cmd)
      CMD_ADD: begin
        if (min < NUM_BINS) begin
          if (bin_count[min] != COUNT_MAX) bin_count[min]++;
          r.count = bin_count[min];
        end
      end
      CMD_LOAD: begin
        if (tp <= MAX_HW) tap_weight[tp] = w;
      end
      CMD_QUERY: begin
        if (min < NUM_BINS) begin
          r.count = bin_count[min];
          h = (half_width > MAX_HW) ? MAX_HW : int'(half_width);
          acc = '0;
          // Walk the window, wrapping around midnight; saturate the sum
          for (int d = -h; d <= h; d++) begin
            idx = (int'(min) + d + NUM_BINS) % NUM_BINS;
            prod = 64'(bin_count[idx]) * 64'(tap_weight[d < 0 ? -d : d]);
            if (prod > SUM_MAX - acc) acc = SUM_MAX;
            else acc += prod;
          end
          r.smooth = acc[SUM_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Hold off results in random bursts
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_stall <= 1'b1;
    end else if (sink_bursts && $urandom_range(0, 7) == 0) begin
      sink_hold <= $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    hist_result_t want;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (histogram_outputs_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: count %0d smoothed %0d", $time,
                 exact_count, smoothed_value);
      end else begin
        want = histogram_outputs_q.pop_front();
        results_checked++;
        if (exact_count !== want.count) begin
          errors++;
          $display("%0t: exact_count expected %0d actual %0d", $time, want.count, exact_count);
        end
        if (smoothed_value !== want.smooth) begin
          errors++;
          $display("%0t: smoothed_value expected %0d actual %0d", $time, want.smooth,
                   smoothed_value);
        end
      end
    end
  end

  // Issue one request and record its predicted result on acceptance
  task automatic send_request(cmd_e cmd, bit [MINUTE_W-1:0] min, bit [TAP_W-1:0] tp,
                              bit [WEIGHT_W-1:0] w);
    @(negedge clk);
    if (src_bursts && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    command <= cmd;
    minute <= min;
    tap <= tp;
    weight <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    histogram_outputs_q.push_back(histogram_update(cmd, min, tp, w));
    case (cmd)
      CMD_ADD:   n_add++;
      CMD_LOAD:  n_load++;
      CMD_QUERY: n_query++;
      default:   n_nop++;
    endcase
  endtask

  // Drop valid and wait until every result is back
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (histogram_outputs_q.size() != 0) @(posedge clk);
  endtask

  // Write the half width register while the block is idle
  task automatic write_half_width(bit [HW_W-1:0] hw);
    wait_results_drained();
    @(negedge clk);
    cfg_half_width <= hw;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    half_width = hw;
    n_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick a minute, mostly clustered around a few hot spots so queries see counts
  function automatic bit [MINUTE_W-1:0] pick_minute();
    int hot_spots [8] = '{0, 1, 2, 719, 720, 1437, 1438, 1439};
    int r;
    int hot;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      hot = hot_spots[$urandom_range(0, 7)];
      return MINUTE_W'((hot + int'($urandom_range(0, 8)) + NUM_BINS - 4) % NUM_BINS);
    end
    if (r < 92) return MINUTE_W'($urandom_range(0, NUM_BINS - 1));
    return MINUTE_W'($urandom_range(NUM_BINS, 2 ** MINUTE_W - 1));
  endfunction

  // Reset leaves an empty histogram and a zero kernel
  task automatic test_after_reset();
    send_request(CMD_QUERY, 11'd0, 7'd0, 20'd0);
    send_request(CMD_QUERY, 11'd1439, '1, '1);
  endtask

  // Field extremes, every command, wrap around midnight, ignored loads
  task automatic test_directed_cases();
    write_half_width(7'd1);
    send_request(CMD_LOAD, 11'd0, 7'd0, 20'h10000);
    send_request(CMD_LOAD, '1, 7'd1, 20'hFFFFF);
    send_request(CMD_LOAD, 11'd0, 7'd64, 20'h08000);
    send_request(CMD_LOAD, 11'd0, 7'd65, 20'hFFFFF);
    send_request(CMD_LOAD, 11'd0, 7'd127, 20'h12345);
    send_request(CMD_ADD, 11'd0, '1, '1);
    send_request(CMD_ADD, 11'd0, 7'd0, 20'd0);
    send_request(CMD_ADD, 11'd1439, 7'd0, 20'd0);
    send_request(CMD_ADD, 11'd1, 7'd0, 20'd0);
    send_request(CMD_ADD, 11'd720, 7'd0, 20'd0);
    send_request(CMD_ADD, 11'd1440, 7'd0, 20'd0);
    send_request(CMD_ADD, 11'd2047, 7'd0, 20'd0);
    send_request(CMD_QUERY, 11'd0, 7'd0, 20'd0);
    send_request(CMD_QUERY, 11'd1439, 7'd0, 20'd0);
    send_request(CMD_QUERY, 11'd2047, 7'd0, 20'd0);
    send_request(CMD_NOP, '1, '1, '1);
    write_half_width(7'd64);
    send_request(CMD_QUERY, 11'd720, 7'd0, 20'd0);
    send_request(CMD_QUERY, 11'd0, 7'd0, 20'd0);
    // Half width above the maximum saturates
    write_half_width(7'd127);
    send_request(CMD_QUERY, 11'd1439, 7'd0, 20'd0);
    send_request(CMD_LOAD, 11'd0, 7'd0, 20'd0);
    send_request(CMD_QUERY, 11'd0, 7'd0, 20'd0);
  endtask

  // Load a full kernel, then mixed traffic over several half widths
  task automatic test_random_traffic();
    bit [HW_W-1:0] widths [6];
    int r;
    cmd_e cmd;
    widths = '{7'd64, 7'd0, 7'd127, 7'd65, HW_W'($urandom_range(1, 63)), 7'd1};
    for (int t = 0; t <= MAX_HW; t++)
      send_request(CMD_LOAD, MINUTE_W'($urandom), TAP_W'(t), WEIGHT_W'($urandom));
    foreach (widths[p]) begin
      write_half_width(widths[p]);
      if (p == 5) begin
        src_bursts = 1'b0;
        sink_bursts = 1'b0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 50) cmd = CMD_ADD;
        else if (r < 62) cmd = CMD_LOAD;
        else if (r < 94) cmd = CMD_QUERY;
        else cmd = CMD_NOP;
        if (cmd == CMD_LOAD)
          send_request(cmd, MINUTE_W'($urandom),
                       ($urandom_range(0, 9) == 0) ? TAP_W'($urandom_range(65, 127))
                                                   : TAP_W'($urandom_range(0, MAX_HW)),
                       ($urandom_range(0, 9) == 0) ? '1 : WEIGHT_W'($urandom));
        else
          send_request(cmd, (cmd == CMD_NOP) ? MINUTE_W'($urandom) : pick_minute(),
                       TAP_W'($urandom), WEIGHT_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_directed_cases();
    test_random_traffic();

    // Let any stray result show up before the verdict
    wait_results_drained();
    repeat (150) @(posedge clk);

    $display("Sent %0d requests: %0d adds, %0d loads, %0d queries, %0d no-ops.",
             n_add + n_load + n_query + n_nop, n_add, n_load, n_query, n_nop);
    $display("Checked %0d results across %0d half width settings, %0d errors.",
             results_checked, n_settings, errors);
    if (errors == 0 && histogram_outputs_q.size() == 0) begin
      $display("circular_histogram_gaussian_smoother test passed");
    end else begin
      $display("circular_histogram_gaussian_smoother test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
